### rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the spline tube tessellator.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    // samples per span, a power of two from 1 to 16
    localparam int SUBDIVISIONS = 4;
    localparam int SUB_LOG2     = $clog2(SUBDIVISIONS);
    // sample denominator is 2 * SUBDIVISIONS^3
    localparam int DEN_LOG2     = 1 + 3 * SUB_LOG2;
    localparam int KW           = $clog2(SUBDIVISIONS + 1);
    // exact numerator width with headroom for the difference terms
    localparam int NW           = 39 + 3 * KW;
    localparam int RW           = NW - DEN_LOG2;
    localparam int QDEPTH       = 2;
    localparam int QAW          = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    typedef logic signed [31:0] coord_t;
    typedef coord_t [2:0]       vec3_t;
    typedef logic [1:0]         cls_t;
    typedef logic signed [NW-1:0] acc_t;
    typedef acc_t [2:0]         acc3_t;
    typedef logic [NW-1:0]      wide_t;
    typedef logic [RW-1:0]      mag_t;
    typedef mag_t [2:0]         mag3_t;
    typedef logic [KW-1:0]      kcnt_t;
    typedef logic [QAW-1:0]     qptr_t;
    typedef logic [QAW:0]       qcnt_t;

    localparam kcnt_t K_LAST     = kcnt_t'(SUBDIVISIONS);
    localparam wide_t ROUND_HALF = wide_t'(1) << (DEN_LOG2 - 1);
    localparam mag_t  POS_LIMIT  = mag_t'(32'h7FFF_FFFF);
    localparam mag_t  NEG_LIMIT  = mag_t'(32'h8000_0000);
    localparam coord_t COORD_MAX = coord_t'(32'h7FFF_FFFF);
    localparam coord_t COORD_MIN = coord_t'(32'h8000_0000);

    typedef struct packed {
        vec3_t p0;
        vec3_t p1;
        vec3_t p2;
        vec3_t p3;
        cls_t  cls;
        logic  step_last;
    } span_job_t;

    typedef struct packed {
        vec3_t q;
        vec3_t p1;
        logic  first;
        logic  step_last;
        cls_t  cls;
    } sample_t;

    typedef struct packed {
        vec3_t s;
        vec3_t e;
        cls_t  cls;
        logic  last;
    } segment_t;

endpackage

`default_nettype wire

### rtl/core/stt_job_queue.sv
// ----------------------------------------------------------------------------
// stt_job_queue
// Short span job queue between the point front end and the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_job_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  stt_pkg::span_job_t  wr_job,
    output logic                full,
    input  logic                rd_en,
    output stt_pkg::span_job_t  rd_job,
    output logic                empty
);

    stt_pkg::span_job_t slot_reg [stt_pkg::QDEPTH];
    stt_pkg::qptr_t     wr_ptr_reg, wr_ptr_next;
    stt_pkg::qptr_t     rd_ptr_reg, rd_ptr_next;
    stt_pkg::qcnt_t     count_reg, count_next;
    logic               do_wr, do_rd;

    assign full   = (count_reg == stt_pkg::qcnt_t'(stt_pkg::QDEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == stt_pkg::qptr_t'(stt_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == stt_pkg::qptr_t'(stt_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

### rtl/core/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Point front end: keeps the trace history and turns each point into zero,
// one or two span jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [31:0]      point_x,
    input  logic signed [31:0]      point_y,
    input  logic signed [31:0]      point_z,
    input  logic [1:0]              span_class,
    input  logic                    trace_end,
    output logic                    job_push,
    output stt_pkg::span_job_t      job,
    input  logic                    job_full
);

    stt_pkg::vec3_t     hist_reg [3];
    stt_pkg::cls_t      hist_cls_reg [3];
    logic [1:0]         count_reg, count_next;
    logic               held_valid_reg, held_valid_next;
    stt_pkg::span_job_t held_job_reg;
    stt_pkg::vec3_t     new_p;
    stt_pkg::span_job_t job_a, job_b;
    logic               accept, has_a, has_b;

    assign full   = job_full || held_valid_reg;
    assign accept = push && !full;
    assign has_a  = (count_reg >= 2'd2);
    assign has_b  = trace_end && (count_reg != 2'd0);

    always_comb
    begin
        new_p[0] = point_x;
        new_p[1] = point_y;
        new_p[2] = point_z;

        job_a.p0        = (count_reg == 2'd3) ? hist_reg[0] : hist_reg[1];
        job_a.p1        = hist_reg[1];
        job_a.p2        = hist_reg[2];
        job_a.p3        = new_p;
        job_a.cls       = hist_cls_reg[1];
        job_a.step_last = !has_b;

        job_b.p0        = (count_reg >= 2'd2) ? hist_reg[1] : hist_reg[2];
        job_b.p1        = hist_reg[2];
        job_b.p2        = new_p;
        job_b.p3        = new_p;
        job_b.cls       = hist_cls_reg[2];
        job_b.step_last = 1'b1;
    end

    // second job of a point waits in the held register until the queue has room
    always_comb
    begin
        job_push        = 1'b0;
        job             = job_a;
        held_valid_next = held_valid_reg;
        count_next      = count_reg;
        if (held_valid_reg)
        begin
            job = held_job_reg;
            if (!job_full)
            begin
                job_push        = 1'b1;
                held_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            job_push        = has_a || has_b;
            job             = has_a ? job_a : job_b;
            held_valid_next = has_a && has_b;
        end
        if (accept)
        begin
            if (trace_end)
            begin
                count_next = 2'd0;
            end
            else if (count_reg != 2'd3)
            begin
                count_next = count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= 2'd0;
            held_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                hist_reg[i]     <= '0;
                hist_cls_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
            if (accept)
            begin
                hist_reg[0]     <= hist_reg[1];
                hist_reg[1]     <= hist_reg[2];
                hist_reg[2]     <= new_p;
                hist_cls_reg[0] <= hist_cls_reg[1];
                hist_cls_reg[1] <= hist_cls_reg[2];
                hist_cls_reg[2] <= span_class;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_a && has_b)
        begin
            held_job_reg <= job_b;
        end
    end

`ifndef NO_ASSERTIONS
    a_held_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (count_reg == 2'd0))
        else $error("second span job held while trace not empty");
`endif

endmodule

`default_nettype wire

### rtl/core/stt_eval.sv
// ----------------------------------------------------------------------------
// stt_eval
// Span evaluator: coefficient stage, forward difference stepper producing
// one curve sample per cycle while the downstream stages are not stalled,
// rounding and saturation stages.
`default_nettype none

module stt_eval (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  stt_pkg::span_job_t  job,
    output logic                job_pop,
    output logic                smp_valid,
    output stt_pkg::sample_t    smp,
    input  logic                smp_ready
);

    // coefficient stage
    logic               c1_valid_reg;
    stt_pkg::vec3_t     c1_p1_reg;
    stt_pkg::acc3_t     c1_a_reg, c1_b_reg, c1_c_reg;
    stt_pkg::cls_t      c1_cls_reg;
    logic               c1_last_reg;
    stt_pkg::acc3_t     c1_a_next, c1_b_next, c1_c_next;

    // forward difference stepper
    logic               it_valid_reg, it_valid_next;
    stt_pkg::kcnt_t     it_k_reg, it_k_next;
    stt_pkg::acc3_t     it_f_reg, it_d1_reg, it_d2_reg, it_d3_reg;
    stt_pkg::vec3_t     it_p1_reg;
    stt_pkg::cls_t      it_cls_reg;
    logic               it_last_reg;
    stt_pkg::acc3_t     ld_b, ld_c, ld_d;
    stt_pkg::acc3_t     ld_f, ld_d1, ld_d2, ld_d3;

    // rounding stage
    logic               rd_valid_reg;
    logic [2:0]         rd_neg_reg, rd_neg_next;
    stt_pkg::mag3_t     rd_mag_reg, rd_mag_next;
    stt_pkg::wide_t     rd_abs [3];
    stt_pkg::wide_t     rd_sum [3];
    stt_pkg::vec3_t     rd_p1_reg;
    logic               rd_first_reg, rd_last_reg;
    stt_pkg::cls_t      rd_cls_reg;

    // saturation stage
    logic               smp_valid_reg;
    stt_pkg::sample_t   smp_reg, smp_next;

    logic               sat_ready, rd_ready, it_adv, it_load, c1_ready, c1_take;

    assign sat_ready = !smp_valid_reg || smp_ready;
    assign rd_ready  = !rd_valid_reg || sat_ready;
    assign it_adv    = it_valid_reg && rd_ready;
    assign it_load   = !it_valid_reg || (it_adv && (it_k_reg == stt_pkg::K_LAST));
    assign c1_ready  = !c1_valid_reg || it_load;
    assign c1_take   = c1_valid_reg && it_load;
    assign job_pop   = job_valid && c1_ready;
    assign smp_valid = smp_valid_reg;
    assign smp       = smp_reg;

    // cubic coefficients per axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c1_a_next[i] = stt_pkg::acc_t'($signed(job.p2[i]))
                         - stt_pkg::acc_t'($signed(job.p0[i]));
            c1_b_next[i] = (stt_pkg::acc_t'($signed(job.p0[i])) <<< 1)
                         - stt_pkg::acc_t'(5) * stt_pkg::acc_t'($signed(job.p1[i]))
                         + (stt_pkg::acc_t'($signed(job.p2[i])) <<< 2)
                         - stt_pkg::acc_t'($signed(job.p3[i]));
            c1_c_next[i] = stt_pkg::acc_t'($signed(job.p3[i]))
                         - stt_pkg::acc_t'($signed(job.p0[i]))
                         + stt_pkg::acc_t'(3) * (stt_pkg::acc_t'($signed(job.p1[i]))
                         - stt_pkg::acc_t'($signed(job.p2[i])));
        end
    end

    // start values at k = 1
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ld_b[i]  = c1_a_reg[i] <<< (2 * stt_pkg::SUB_LOG2);
            ld_c[i]  = c1_b_reg[i] <<< stt_pkg::SUB_LOG2;
            ld_d[i]  = c1_c_reg[i];
            ld_f[i]  = (stt_pkg::acc_t'($signed(c1_p1_reg[i])) <<< stt_pkg::DEN_LOG2)
                     + ld_b[i] + ld_c[i] + ld_d[i];
            ld_d1[i] = ld_b[i] + stt_pkg::acc_t'(3) * ld_c[i]
                     + stt_pkg::acc_t'(7) * ld_d[i];
            ld_d2[i] = (ld_c[i] <<< 1) + stt_pkg::acc_t'(12) * ld_d[i];
            ld_d3[i] = stt_pkg::acc_t'(6) * ld_d[i];
        end
    end

    always_comb
    begin
        it_valid_next = it_valid_reg;
        it_k_next     = it_k_reg;
        if (it_load)
        begin
            it_valid_next = c1_valid_reg;
            it_k_next     = stt_pkg::kcnt_t'(1);
        end
        else if (it_adv)
        begin
            it_k_next = it_k_reg + 1'b1;
        end
    end

    // round half away from zero on the magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rd_neg_next[i] = it_f_reg[i][stt_pkg::NW-1];
            rd_abs[i]      = rd_neg_next[i] ? stt_pkg::wide_t'(-it_f_reg[i])
                                            : stt_pkg::wide_t'(it_f_reg[i]);
            rd_sum[i]      = rd_abs[i] + stt_pkg::ROUND_HALF;
            rd_mag_next[i] = rd_sum[i][stt_pkg::NW-1:stt_pkg::DEN_LOG2];
        end
    end

    always_comb
    begin
        smp_next.p1        = rd_p1_reg;
        smp_next.first     = rd_first_reg;
        smp_next.step_last = rd_last_reg;
        smp_next.cls       = rd_cls_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (rd_neg_reg[i])
            begin
                smp_next.q[i] = (rd_mag_reg[i] > stt_pkg::NEG_LIMIT) ? stt_pkg::COORD_MIN
                              : stt_pkg::coord_t'(-rd_mag_reg[i]);
            end
            else
            begin
                smp_next.q[i] = (rd_mag_reg[i] > stt_pkg::POS_LIMIT) ? stt_pkg::COORD_MAX
                              : stt_pkg::coord_t'(rd_mag_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg  <= 1'b0;
            it_valid_reg  <= 1'b0;
            it_k_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            smp_valid_reg <= 1'b0;
        end
        else
        begin
            if (c1_ready)
            begin
                c1_valid_reg <= job_valid;
            end
            it_valid_reg <= it_valid_next;
            it_k_reg     <= it_k_next;
            if (rd_ready)
            begin
                rd_valid_reg <= it_valid_reg;
            end
            if (sat_ready)
            begin
                smp_valid_reg <= rd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            c1_p1_reg   <= job.p1;
            c1_a_reg    <= c1_a_next;
            c1_b_reg    <= c1_b_next;
            c1_c_reg    <= c1_c_next;
            c1_cls_reg  <= job.cls;
            c1_last_reg <= job.step_last;
        end
        if (c1_take)
        begin
            it_f_reg    <= ld_f;
            it_d1_reg   <= ld_d1;
            it_d2_reg   <= ld_d2;
            it_d3_reg   <= ld_d3;
            it_p1_reg   <= c1_p1_reg;
            it_cls_reg  <= c1_cls_reg;
            it_last_reg <= c1_last_reg;
        end
        else if (it_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                it_f_reg[i]  <= it_f_reg[i] + it_d1_reg[i];
                it_d1_reg[i] <= it_d1_reg[i] + it_d2_reg[i];
                it_d2_reg[i] <= it_d2_reg[i] + it_d3_reg[i];
            end
        end
        if (it_adv)
        begin
            rd_neg_reg   <= rd_neg_next;
            rd_mag_reg   <= rd_mag_next;
            rd_p1_reg    <= it_p1_reg;
            rd_first_reg <= (it_k_reg == stt_pkg::kcnt_t'(1));
            rd_last_reg  <= it_last_reg && (it_k_reg == stt_pkg::K_LAST);
            rd_cls_reg   <= it_cls_reg;
        end
        if (sat_ready && rd_valid_reg)
        begin
            smp_reg <= smp_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_k_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        it_valid_reg |-> ((it_k_reg != '0) && (it_k_reg <= stt_pkg::K_LAST)))
        else $error("sample index outside the span");
`endif

endmodule

`default_nettype wire

### rtl/core/stt_emit.sv
// ----------------------------------------------------------------------------
// stt_emit
// Segment builder: pairs consecutive samples, drops flat segments, holds the
// newest segment until it is known whether it closes its point's run.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                smp_valid,
    input  stt_pkg::sample_t    smp,
    output logic                smp_ready,
    output logic                seg_valid,
    output stt_pkg::segment_t   seg,
    input  logic                pop
);

    stt_pkg::vec3_t     prev_reg;
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_closed_reg, pend_closed_next;
    stt_pkg::segment_t  pend_reg;
    logic               out_valid_reg, out_valid_next;
    stt_pkg::segment_t  out_reg;
    stt_pkg::vec3_t     ref_p;
    logic               moved, out_ready, drain, take;

    assign ref_p     = smp.first ? smp.p1 : prev_reg;
    assign moved     = (smp.q != ref_p);
    assign out_ready = !out_valid_reg || pop;
    assign drain     = pend_valid_reg && out_ready
                     && (pend_closed_reg || (smp_valid && moved));
    assign smp_ready = !moved || !pend_valid_reg || drain;
    assign take      = smp_valid && smp_ready;
    assign seg_valid = out_valid_reg;
    assign seg       = out_reg;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        pend_valid_next  = pend_valid_reg;
        pend_closed_next = pend_closed_reg;
        if (drain)
        begin
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (take && moved)
        begin
            pend_valid_next  = 1'b1;
            pend_closed_next = smp.step_last;
        end
        else if (take && smp.step_last)
        begin
            pend_closed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_closed_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            pend_valid_reg  <= pend_valid_next;
            pend_closed_reg <= pend_closed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prev_reg <= smp.q;
        end
        if (take && moved)
        begin
            pend_reg.s    <= ref_p;
            pend_reg.e    <= smp.q;
            pend_reg.cls  <= smp.cls;
            pend_reg.last <= 1'b0;
        end
        if (drain)
        begin
            out_reg.s    <= pend_reg.s;
            out_reg.e    <= pend_reg.e;
            out_reg.cls  <= pend_reg.cls;
            out_reg.last <= pend_closed_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_flat_segment: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.s != out_reg.e))
        else $error("segment with equal endpoints reached the output");

    a_pend_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (take && moved) |=> pend_valid_reg)
        else $error("new segment not held after sample taken");

    a_closed_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && pend_closed_reg && out_ready) |=> out_valid_reg)
        else $error("closed segment did not move to the output");
`endif

endmodule

`default_nettype wire

### rtl/core/spline_tube_tessellator.sv
// ----------------------------------------------------------------------------
// spline_tube_tessellator
// Catmull-Rom smoothing of 3D trace points into short line segments.
// ----------------------------------------------------------------------------
// Input queue side: drive a point on point_x/y/z, span_class and trace_end
// and raise push; the request is taken on a clock edge where full is low.
// Output queue side: while empty is low the oldest segment is on start_*,
// end_*, segment_class and last_of_run; pop takes it on a clock edge.
// Each point yields up to two spans of SUBDIVISIONS segments each; segments
// with equal endpoints are dropped and last_of_run marks the final segment
// that a point produced. A point that produces no segment gives no request.
// Throughput: the forward difference stepper makes one curve sample per
// cycle while the output side does not stall it, and a span has SUBDIVISIONS
// samples (4). Points are taken back to back while the span queue has room
// and no second span job of a trace end point is held.
// Path: span queue, coefficient, stepper, rounding and saturation stages,
// segment builder; the final segment of a point waits until its spans end.
// Reset empties the trace history and all pipeline stages. When the receiver
// stops popping, the stages fill, the span queue fills and full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module spline_tube_tessellator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    input  logic [1:0]          span_class,
    input  logic                trace_end,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  start_x,
    output logic signed [31:0]  start_y,
    output logic signed [31:0]  start_z,
    output logic signed [31:0]  end_x,
    output logic signed [31:0]  end_y,
    output logic signed [31:0]  end_z,
    output logic [1:0]          segment_class,
    output logic                last_of_run
);

    logic               job_push, job_full, job_pop, job_empty;
    stt_pkg::span_job_t job_in, job_out;
    logic               smp_valid, smp_ready, seg_valid;
    stt_pkg::sample_t   smp;
    stt_pkg::segment_t  seg;

    stt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .span_class (span_class),
        .trace_end  (trace_end),
        .job_push   (job_push),
        .job        (job_in),
        .job_full   (job_full)
    );

    stt_job_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .full   (job_full),
        .rd_en  (job_pop),
        .rd_job (job_out),
        .empty  (job_empty)
    );

    stt_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .smp_valid (smp_valid),
        .smp       (smp),
        .smp_ready (smp_ready)
    );

    stt_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp       (smp),
        .smp_ready (smp_ready),
        .seg_valid (seg_valid),
        .seg       (seg),
        .pop       (pop)
    );

    assign empty         = !seg_valid;
    assign start_x       = seg.s[0];
    assign start_y       = seg.s[1];
    assign start_z       = seg.s[2];
    assign end_x         = seg.e[0];
    assign end_y         = seg.e[1];
    assign end_z         = seg.e[2];
    assign segment_class = seg.cls;
    assign last_of_run   = seg.last;

endmodule

`default_nettype wire

### test/spline_tube_tessellator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_tube_tessellator_checker
// Watches both queue sides of the tessellator, predicts the segments of
// every accepted point request with an exact Catmull-Rom evaluation, and
// compares each popped segment field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module spline_tube_tessellator_checker
    import stt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  logic    full,
    input  coord_t  point_x,
    input  coord_t  point_y,
    input  coord_t  point_z,
    input  cls_t    span_class,
    input  logic    trace_end,
    input  logic    empty,
    input  logic    pop,
    input  coord_t  start_x,
    input  coord_t  start_y,
    input  coord_t  start_z,
    input  coord_t  end_x,
    input  coord_t  end_y,
    input  coord_t  end_z,
    input  cls_t    segment_class,
    input  logic    last_of_run,
    output int      failures,
    output int      outstanding,
    output int      points_taken,
    output int      segments_checked
);

    coord_t   hist_x [3];
    coord_t   hist_y [3];
    coord_t   hist_z [3];
    cls_t     hist_cls [3];
    int       held;
    coord_t   win_x [4];
    coord_t   win_y [4];
    coord_t   win_z [4];
    segment_t step_segs [$];
    segment_t pending_segments [$];
    segment_t want;
    segment_t got;
    int       fail_count;
    int       point_count;
    int       seg_count;
    string    axis_name [3] = '{"x", "y", "z"};

    function automatic coord_t curve_sample(input longint p0, input longint p1,
                                            input longint p2, input longint p3,
                                            input longint k);
        longint s;
        longint den;
        longint num;
        longint q;
        s   = SUBDIVISIONS;
        den = 2 * s * s * s;
        num = 2 * p1 * s * s * s
            + (p2 - p0) * k * s * s
            + (2 * p0 - 5 * p1 + 4 * p2 - p3) * k * k * s
            + (-p0 + 3 * p1 - 3 * p2 + p3) * k * k * k;
        // round half away from zero
        if (num >= 0)
            q = (num + den / 2) / den;
        else
            q = -((-num + den / 2) / den);
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return coord_t'(q);
    endfunction

    task automatic tessellate_span(input int i0, input int i1, input int i2, input int i3,
                                   input cls_t c);
        vec3_t    prev;
        vec3_t    cur;
        segment_t s;
        prev[0] = curve_sample(win_x[i0], win_x[i1], win_x[i2], win_x[i3], 0);
        prev[1] = curve_sample(win_y[i0], win_y[i1], win_y[i2], win_y[i3], 0);
        prev[2] = curve_sample(win_z[i0], win_z[i1], win_z[i2], win_z[i3], 0);
        for (int k = 1; k <= SUBDIVISIONS; k++)
        begin
            cur[0] = curve_sample(win_x[i0], win_x[i1], win_x[i2], win_x[i3], k);
            cur[1] = curve_sample(win_y[i0], win_y[i1], win_y[i2], win_y[i3], k);
            cur[2] = curve_sample(win_z[i0], win_z[i1], win_z[i2], win_z[i3], k);
            // coincident endpoints give no segment
            if (cur != prev)
            begin
                s.s    = prev;
                s.e    = cur;
                s.cls  = c;
                s.last = 1'b0;
                step_segs = {step_segs, s};
            end
            prev = cur;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hist_x[i]   = '0;
                hist_y[i]   = '0;
                hist_z[i]   = '0;
                hist_cls[i] = '0;
            end
            held = 0;
            pending_segments.delete();
            fail_count  = 0;
            point_count = 0;
            seg_count   = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got.s[0] = start_x;
                got.s[1] = start_y;
                got.s[2] = start_z;
                got.e[0] = end_x;
                got.e[1] = end_y;
                got.e[2] = end_z;
                got.cls  = segment_class;
                got.last = last_of_run;
                seg_count++;
                if (pending_segments.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: segment expected none actual (%0d,%0d,%0d)-(%0d,%0d,%0d)",
                             $time, start_x, start_y, start_z, end_x, end_y, end_z);
                end
                else
                begin
                    want = pending_segments.pop_front();
                    for (int a = 0; a < 3; a++)
                    begin
                        if (got.s[a] !== want.s[a])
                        begin
                            fail_count++;
                            $display("%0t: start_%s expected %0d actual %0d",
                                     $time, axis_name[a], want.s[a], got.s[a]);
                        end
                        if (got.e[a] !== want.e[a])
                        begin
                            fail_count++;
                            $display("%0t: end_%s expected %0d actual %0d",
                                     $time, axis_name[a], want.e[a], got.e[a]);
                        end
                    end
                    if (got.cls !== want.cls)
                    begin
                        fail_count++;
                        $display("%0t: segment_class expected %0d actual %0d",
                                 $time, want.cls, got.cls);
                    end
                    if (got.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, want.last, got.last);
                    end
                end
            end

            if (push && !full)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_x[i] = hist_x[i];
                    win_y[i] = hist_y[i];
                    win_z[i] = hist_z[i];
                end
                win_x[3] = point_x;
                win_y[3] = point_y;
                win_z[3] = point_z;
                step_segs.delete();
                // ends of a trace repeat the end point as the outer control
                if (held >= 2)
                    tessellate_span((held == 3) ? 0 : 1, 1, 2, 3, hist_cls[1]);
                if (trace_end && held >= 1)
                    tessellate_span((held >= 2) ? 1 : 2, 2, 3, 3, hist_cls[2]);
                if (step_segs.size() > 0)
                    step_segs[step_segs.size() - 1].last = 1'b1;
                pending_segments = {pending_segments, step_segs};
                for (int i = 0; i < 2; i++)
                begin
                    hist_x[i]   = hist_x[i + 1];
                    hist_y[i]   = hist_y[i + 1];
                    hist_z[i]   = hist_z[i + 1];
                    hist_cls[i] = hist_cls[i + 1];
                end
                hist_x[2]   = point_x;
                hist_y[2]   = point_y;
                hist_z[2]   = point_z;
                hist_cls[2] = span_class;
                if (trace_end)
                    held = 0;
                else if (held < 3)
                    held = held + 1;
                point_count++;
            end
        end
        failures         <= fail_count;
        outstanding      <= pending_segments.size();
        points_taken     <= point_count;
        segments_checked <= seg_count;
    end

endmodule

### test/spline_tube_tessellator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_tube_tessellator_test
// Drives trace points into the tessellator: directed traces for single
// points, duplicated trace ends, overshoot saturation, coincident samples
// and every class, then random traces with random idling on both sides and
// one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

module spline_tube_tessellator_test;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int POINT_TARGET = 500;
    localparam int HOLD_CYCLES  = 300;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   push;
    logic   full;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    cls_t   span_class;
    logic   trace_end;
    logic   empty;
    logic   pop;
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    cls_t   segment_class;
    logic   last_of_run;

    int     failures;
    int     outstanding;
    int     points_taken;
    int     segments_checked;
    int     points_sent = 0;
    int     traces_sent = 0;
    int     cycle_count = 0;
    int     stall_cycles = 0;
    bit     idle_on = 1'b1;
    bit     hold_done = 1'b0;

    spline_tube_tessellator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .span_class    (span_class),
        .trace_end     (trace_end),
        .empty         (empty),
        .pop           (pop),
        .start_x       (start_x),
        .start_y       (start_y),
        .start_z       (start_z),
        .end_x         (end_x),
        .end_y         (end_y),
        .end_z         (end_z),
        .segment_class (segment_class),
        .last_of_run   (last_of_run)
    );

    spline_tube_tessellator_checker segment_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .point_x          (point_x),
        .point_y          (point_y),
        .point_z          (point_z),
        .span_class       (span_class),
        .trace_end        (trace_end),
        .empty            (empty),
        .pop              (pop),
        .start_x          (start_x),
        .start_y          (start_y),
        .start_z          (start_z),
        .end_x            (end_x),
        .end_y            (end_y),
        .end_z            (end_z),
        .segment_class    (segment_class),
        .last_of_run      (last_of_run),
        .failures         (failures),
        .outstanding      (outstanding),
        .points_taken     (points_taken),
        .segments_checked (segments_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (push && full)
            stall_cycles++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                              input cls_t c, input logic last);
        bit taken;
        taken = 1'b0;
        idle_on = !(points_sent >= 250 && points_sent < 350);
        while (!taken)
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(99) < 18)
            begin
                push <= 1'b0;
            end
            else
            begin
                push       <= 1'b1;
                point_x    <= x;
                point_y    <= y;
                point_z    <= z;
                span_class <= c;
                trace_end  <= last;
                @(posedge clk);
                taken = !full;
            end
        end
        points_sent++;
        if (last)
            traces_sent++;
    endtask

    function automatic coord_t pick_coord(input int mode, input coord_t base);
        int r;
        case (mode)
            0: return coord_t'($urandom);
            1: return base + coord_t'($urandom_range(6)) - 32'sd3;
            2:
            begin
                r = $urandom_range(4);
                case (r)
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    3: return -32'sd1;
                    default: return base;
                endcase
            end
            default: return base + coord_t'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    // receiver side, with one long hold-off once the run is under way
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!hold_done && points_sent >= 120)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
            begin
                pop <= !(idle_on && $urandom_range(99) < 18);
            end
        end
    end

    initial
    begin : stimulus
        int     len;
        int     mode;
        cls_t   c;
        coord_t bx;
        coord_t by;
        coord_t bz;
        rst_n      = 1'b0;
        push       = 1'b0;
        point_x    = '0;
        point_y    = '0;
        point_z    = '0;
        span_class = '0;
        trace_end  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single point trace
        send_point(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_0005, 2'd0, 1'b1);
        // two points, both ends duplicated
        send_point('0, '0, '0, 2'd1, 1'b0);
        send_point(32'sh0004_0000, -32'sh0002_0000, 32'sh0001_0000, 2'd2, 1'b1);
        // bulge past the coordinate limits
        send_point(COORD_MIN, COORD_MAX, '0, 2'd0, 1'b0);
        send_point(COORD_MAX, COORD_MIN, -32'sd1, 2'd1, 1'b0);
        send_point(COORD_MAX, COORD_MIN, -32'sd1, 2'd2, 1'b0);
        send_point(COORD_MIN, COORD_MAX, '0, 2'd3, 1'b1);
        // all samples coincide
        send_point(32'sd12345, -32'sd6789, 32'sd42, 2'd0, 1'b0);
        send_point(32'sd12345, -32'sd6789, 32'sd42, 2'd1, 1'b0);
        send_point(32'sd12345, -32'sd6789, 32'sd42, 2'd2, 1'b0);
        send_point(32'sd12345, -32'sd6789, 32'sd42, 2'd3, 1'b1);
        // single step moves, some samples coincide
        send_point('0, '0, '0, 2'd0, 1'b0);
        send_point(32'sd1, '0, '0, 2'd1, 1'b0);
        send_point(32'sd1, 32'sd1, '0, 2'd2, 1'b0);
        send_point(32'sd2, 32'sd1, 32'sd1, 2'd3, 1'b1);
        // longer trace, history full
        send_point(32'sh0010_0000, 32'sh0020_0000, -32'sh0030_0000, 2'd3, 1'b0);
        send_point(-32'sh0008_0000, 32'sh0021_8000, -32'sh0028_0000, 2'd1, 1'b0);
        send_point(32'sh0003_4567, 32'sh0019_0000, -32'sh0035_1234, 2'd1, 1'b0);
        send_point(32'sh7000_0000, -32'sh7000_0000, 32'sh0000_0001, 2'd2, 1'b0);
        send_point(-32'sh0000_0003, 32'sh0000_0007, 32'sh0012_0000, 2'd0, 1'b0);
        send_point(32'sh0000_ffff, -32'sh0000_ffff, 32'sh0013_0000, 2'd2, 1'b1);

        while (points_sent < POINT_TARGET)
        begin
            mode = $urandom_range(3);
            len  = $urandom_range(99);
            if (len < 10)
                len = 1;
            else if (len < 85)
                len = $urandom_range(8, 2);
            else
                len = $urandom_range(20, 9);
            bx = coord_t'($urandom);
            by = coord_t'($urandom);
            bz = coord_t'($urandom);
            for (int i = 0; i < len; i++)
            begin
                bx = pick_coord(mode, bx);
                by = pick_coord(mode, by);
                bz = pick_coord(mode, bz);
                c  = ($urandom_range(7) == 0) ? cls_t'(3) : cls_t'($urandom_range(2));
                send_point(bx, by, bz, c, i == len - 1);
            end
        end
        @(negedge clk);
        push <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d points in %0d traces taken, %0d segments compared",
                 points_taken, traces_sent, segments_checked);
        $display("input held off by a full block for %0d cycles", stall_cycles);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/stt_pkg.sv
rtl/core/stt_job_queue.sv
rtl/core/stt_front.sv
rtl/core/stt_eval.sv
rtl/core/stt_emit.sv
rtl/core/spline_tube_tessellator.sv
test/spline_tube_tessellator_checker.sv
test/spline_tube_tessellator_test.sv
